### src/t2a_pkg.sv
// ---------------------------------------------------------------------------
// t2a_pkg
// Constants, encoding tables and the halfword decode function for the
// thumb-to-arm instruction translator.
// ---------------------------------------------------------------------------
package t2a_pkg;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BRANCH = 2'd1,
        ST_UNDEF  = 2'd2
    } t_status;

    typedef struct packed {
        logic [31:0] word;
        t_status     status;
    } t_xlat;

    localparam int          SWI_CODE_W     = 24;
    localparam logic [23:0] SWI_CODE_RESET = 24'h180000;
    localparam logic [31:0] FILLER_WORD    = 32'hDEADC0DE;
    localparam logic [1:0]  LENGTH_BYTES   = 2'd2;
    localparam logic [31:0] SWI_BASE       = 32'hEF000000;
    localparam logic [7:0]  SWI_IMM_SEMI   = 8'h18;
    localparam logic [7:0]  SWI_IMM_BKPT   = 8'hFE;

    // alu op kinds
    localparam logic [1:0] ALU_PLAIN = 2'd0;
    localparam logic [1:0] ALU_SHIFT = 2'd1;
    localparam logic [1:0] ALU_NEG   = 2'd2;
    localparam logic [1:0] ALU_MUL   = 2'd3;

    // misc group ops, bits 11..8
    localparam logic [3:0] MISC_SP_ADJ = 4'h0;
    localparam logic [3:0] MISC_EXT    = 4'h2;
    localparam logic [3:0] MISC_CPS    = 4'h6;
    localparam logic [3:0] MISC_REV    = 4'hA;
    localparam logic [3:0] MISC_BKPT   = 4'hE;
    localparam logic [1:0] REV_UNDEF   = 2'd2;

    localparam logic [3:0] COND_UNDEF  = 4'hE;
    localparam logic [3:0] COND_SWI    = 4'hF;

    localparam logic [31:0] ADDSUB3_BASE [4] = '{
        32'hE0900000, 32'hE0500000, 32'hE2900000, 32'hE2500000
    };
    localparam logic [31:0] IMM8_BASE [4] = '{
        32'hE3B00000, 32'hE3500000, 32'hE2900000, 32'hE2500000
    };
    localparam logic [31:0] ALU_BASE [16] = '{
        32'hE0100000, 32'hE0300000, 32'hE1B00010, 32'hE1B00030,
        32'hE1B00050, 32'hE0B00000, 32'hE0D00000, 32'hE1B00070,
        32'hE1100000, 32'hE2700000, 32'hE1500000, 32'hE1700000,
        32'hE1900000, 32'hE0100090, 32'hE1D00000, 32'hE1F00000
    };
    localparam logic [1:0] ALU_KIND [16] = '{
        ALU_PLAIN, ALU_PLAIN, ALU_SHIFT, ALU_SHIFT,
        ALU_SHIFT, ALU_PLAIN, ALU_PLAIN, ALU_SHIFT,
        ALU_PLAIN, ALU_NEG,   ALU_PLAIN, ALU_PLAIN,
        ALU_PLAIN, ALU_MUL,   ALU_PLAIN, ALU_PLAIN
    };
    localparam logic [31:0] LDST_REG_BASE [8] = '{
        32'hE7800000, 32'hE18000B0, 32'hE7C00000, 32'hE19000D0,
        32'hE7900000, 32'hE19000B0, 32'hE7D00000, 32'hE19000F0
    };
    localparam logic [31:0] LDST_IMM_BASE [4] = '{
        32'hE5800000, 32'hE5900000, 32'hE5C00000, 32'hE5D00000
    };
    localparam logic [31:0] REV_BASE [4] = '{
        32'hE6BF0F30, 32'hE6BF0FB0, 32'h00000000, 32'hE6FF0FB0
    };
    localparam logic [31:0] EXT_BASE [4] = '{
        32'hE6BF0070, 32'hE6AF0070, 32'hE6FF0070, 32'hE6EF0070
    };
    localparam logic [31:0] PUSHPOP_BASE [4] = '{
        32'hE92D0000, 32'hE92D4000, 32'hE8BD0000, 32'hE8BD8000
    };

    function automatic t_xlat translate(input logic [15:0] t, input logic [23:0] swi_code);
        t_xlat       r;
        logic [2:0]  rd;
        logic [2:0]  rs;
        logic [2:0]  rh;
        logic [4:0]  cls;
        logic [3:0]  hd;
        logic [3:0]  hs;
        logic [3:0]  aop;
        logic [31:0] b;
        logic        wb;
        rd  = t[2:0];
        rs  = t[5:3];
        rh  = t[10:8];
        cls = t[15:11];
        hd  = {t[7], rd};
        hs  = {t[6], rs};
        aop = t[9:6];
        b   = ALU_BASE[aop];
        wb  = ~t[rh];
        r.word   = FILLER_WORD;
        r.status = ST_OK;
        unique case (cls)
            5'd0, 5'd1, 5'd2: begin
                r.word = 32'hE1B00000 | {17'd0, rd, t[10:6], t[12:11], 2'b00, rs};
            end
            5'd3: begin
                r.word = ADDSUB3_BASE[t[10:9]] | {13'd0, rs, 1'b0, rd, 9'd0, t[8:6]};
            end
            5'd4, 5'd5, 5'd6, 5'd7: begin
                r.word = IMM8_BASE[cls[1:0]] | {13'd0, rh, 1'b0, rh, 4'd0, t[7:0]};
            end
            5'd8: begin
                if (!t[10]) begin
                    unique case (ALU_KIND[aop])
                        ALU_PLAIN: r.word = b | {13'd0, rd, 1'b0, rd, 9'd0, rs};
                        ALU_SHIFT: r.word = b | {17'd0, rd, 1'b0, rs, 5'd0, rd};
                        ALU_NEG:   r.word = b | {13'd0, rs, 1'b0, rd, 12'd0};
                        default:   r.word = b | {13'd0, rd, 5'd0, rd, 5'd0, rs};
                    endcase
                end else begin
                    priority if (t[9:8] == 2'd0) begin
                        r.word = 32'hE0800000 | {12'd0, hd, hd, 8'd0, hs};
                    end else if (t[9:8] == 2'd1) begin
                        r.word = 32'hE1500000 | {12'd0, hd, hd, 8'd0, hs};
                    end else if (t[9:8] == 2'd2) begin
                        r.word = 32'hE1A00000 | {12'd0, hd, hd, 8'd0, hs};
                    end else if (!t[7]) begin
                        r.word = 32'hE12FFF10 | {28'd0, hs};
                    end else begin
                        r.word = 32'hE1200030 | {28'd0, hs};
                    end
                end
            end
            5'd9: begin
                r.word = 32'hE59F0000 | {17'd0, rh, 2'd0, t[7:0], 2'b00};
            end
            5'd10, 5'd11: begin
                r.word = LDST_REG_BASE[t[11:9]] | {13'd0, rs, 1'b0, rd, 9'd0, t[8:6]};
            end
            5'd12, 5'd13, 5'd14, 5'd15: begin
                // byte forms keep the offset unscaled, word forms scale by four
                r.word = LDST_IMM_BASE[cls[1:0]] | {13'd0, rs, 1'b0, rd, 12'd0}
                       | (t[12] ? {27'd0, t[10:6]} : {25'd0, t[10:6], 2'b00});
            end
            5'd16, 5'd17: begin
                r.word = (t[11] ? 32'hE1D000B0 : 32'hE1C000B0)
                       | {13'd0, rs, 1'b0, rd, 2'd0, t[10:9], 4'd0, t[8:6], 1'b0};
            end
            5'd18, 5'd19: begin
                r.word = (t[11] ? 32'hE59D0000 : 32'hE58D0000)
                       | {17'd0, rh, 2'd0, t[7:0], 2'b00};
            end
            5'd20, 5'd21: begin
                r.word = (t[11] ? 32'hE28D0F00 : 32'hE28F0F00)
                       | {17'd0, rh, 4'd0, t[7:0]};
            end
            5'd22, 5'd23: begin
                priority if (t[11:8] == MISC_SP_ADJ) begin
                    r.word = (t[7] ? 32'hE24DDF00 : 32'hE28DDF00) | {25'd0, t[6:0]};
                end else if (t[11:8] == MISC_BKPT) begin
                    r.word = SWI_BASE | {20'd0, t[7:4], 4'd0, t[3:0]};
                end else if (t[11:8] == MISC_CPS) begin
                    if (!t[5]) begin
                        r.word = 32'hF1010000 | {22'd0, t[3], 9'd0};
                    end else begin
                        r.word = 32'hF1080000 | {13'd0, t[4], 9'd0, t[2], t[1], t[0], 6'd0};
                    end
                end else if (t[11:8] == MISC_REV) begin
                    if (t[7:6] == REV_UNDEF) begin
                        r.status = ST_UNDEF;
                    end else begin
                        r.word = REV_BASE[t[7:6]] | {17'd0, rd, 9'd0, rs};
                    end
                end else if (t[10:9] == 2'b10) begin
                    r.word = PUSHPOP_BASE[{t[11], t[8]}] | {24'd0, t[7:0]};
                end else if (t[11:8] == MISC_EXT) begin
                    r.word = EXT_BASE[t[7:6]] | {17'd0, rd, 9'd0, rs};
                end else begin
                    r.status = ST_UNDEF;
                end
            end
            5'd24, 5'd25: begin
                // base register in the list suppresses writeback
                r.word = (t[11] ? (wb ? 32'hE8B00000 : 32'hE8900000)
                                : (wb ? 32'hE8A00000 : 32'hE8800000))
                       | {13'd0, rh, 8'd0, t[7:0]};
            end
            5'd26, 5'd27: begin
                priority if (t[11:8] == COND_SWI) begin
                    priority if (t[7:0] == SWI_IMM_SEMI) begin
                        r.word = SWI_BASE | {8'd0, t[7:0], 16'd0};
                    end else if (t[7:0] == SWI_IMM_BKPT) begin
                        r.word = SWI_BASE | {8'd0, swi_code};
                    end else begin
                        r.word = SWI_BASE | {24'd0, t[7:0]};
                    end
                end else if (t[11:8] == COND_UNDEF) begin
                    r.status = ST_UNDEF;
                end else begin
                    r.status = ST_BRANCH;
                end
            end
            5'd29: begin
                r.status = t[0] ? ST_UNDEF : ST_BRANCH;
            end
            default: begin
                r.status = ST_BRANCH;
            end
        endcase
        if (r.status != ST_OK) begin
            r.word = FILLER_WORD;
        end
        return r;
    endfunction

endpackage

### src/thumb_to_arm_translate.sv
// ---------------------------------------------------------------------------
// thumb_to_arm_translate
// Rebuilds a 16-bit thumb instruction as its 32-bit arm encoding.
// ---------------------------------------------------------------------------
// an item passes the input register, the decode and the result register in turn;
//   throughput one item every cycle, busy stays low
// the decode is one level of field selection between those two registers
// results are never held off, each stays on the ports for exactly one cycle
// synchronous active-low reset clears both valid flags and sets the swi code
//   to 0x180000
module thumb_to_arm_translate (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_fetch_word,
    input  logic [1:0]  i_addr_low,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data,
    output logic        o_valid,
    output logic [31:0] o_arm_word,
    output logic [1:0]  o_status,
    output logic [1:0]  o_length_bytes
);

    logic        r_in_valid;
    logic [15:0] r_half;
    logic [t2a_pkg::SWI_CODE_W-1:0] r_swi_code;
    logic        r_out_valid;
    logic [31:0] r_arm_word;
    logic [1:0]  r_status;

    logic          accept;
    t2a_pkg::t_xlat n_xlat;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swi_code <= t2a_pkg::SWI_CODE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_swi_code <= i_cfg_data;
        end
    end

    // any nonzero low address bits pick the upper halfword
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
        if (accept) begin
            r_half <= (i_addr_low != 2'd0) ? i_fetch_word[31:16] : i_fetch_word[15:0];
        end
    end

    always_comb begin
        n_xlat = t2a_pkg::translate(r_half, r_swi_code);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
        if (r_in_valid) begin
            r_arm_word <= n_xlat.word;
            r_status   <= n_xlat.status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_arm_word     = r_arm_word;
    assign o_status       = r_status;
    assign o_length_bytes = t2a_pkg::LENGTH_BYTES;

    a_filler_when_not_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != t2a_pkg::ST_OK) |-> o_arm_word == t2a_pkg::FILLER_WORD)
        else $error("untranslated item without filler word");

    a_status_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == t2a_pkg::ST_OK) || (o_status == t2a_pkg::ST_BRANCH)
                    || (o_status == t2a_pkg::ST_UNDEF))
        else $error("status code out of range");

    a_strobe_has_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 2) && $past(i_rst_n, 1))
        else $error("result strobe without an accepted item");

    a_item_gives_strobe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept ##1 i_rst_n |=> o_valid)
        else $error("accepted item lost");

endmodule
